// ===== hdl/tcl_pkg.sv =====
// Shared types and constants for the triangle coverage pipeline.
// No dependencies; every module of the block imports this package.
`default_nettype none
package tcl_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int COORD_FRAC_BITS = 24;
  localparam int EPS_WIDTH       = 25;
  localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(168);

  localparam int DIFF_W    = COORD_WIDTH + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int EDGE_W    = PROD_W + 1;
  localparam int AREA_W    = EDGE_W + 2;
  localparam int AREA_LO_W = AREA_W / 2;
  localparam int AREA_HI_W = AREA_W - AREA_LO_W;
  localparam int TOL_W     = AREA_W + EPS_WIDTH;
  localparam int CMP_W     = ((COORD_FRAC_BITS > EPS_WIDTH) ? COORD_FRAC_BITS : EPS_WIDTH)
                             + AREA_W + 2;

  typedef logic signed [COORD_WIDTH-1:0] tcl_coord_t;
  typedef logic signed [DIFF_W-1:0]      tcl_diff_t;
  typedef logic signed [PROD_W-1:0]      tcl_prod_t;
  typedef logic signed [EDGE_W-1:0]      tcl_edge_t;
  typedef logic signed [AREA_W-1:0]      tcl_wide_t;

  typedef struct packed {
    tcl_coord_t u0;
    tcl_coord_t v0;
    tcl_coord_t u1;
    tcl_coord_t v1;
    tcl_coord_t u2;
    tcl_coord_t v2;
    tcl_coord_t pu;
    tcl_coord_t pv;
  } tcl_item_t;

  typedef struct packed {
    logic [2:0] fwd;
    logic [2:0] rev;
  } tcl_tl_t;

  typedef struct packed {
    tcl_edge_t [2:0] e;
    tcl_tl_t         tl;
  } tcl_edges_t;

  typedef struct packed {
    tcl_wide_t [2:0]   e;
    logic [AREA_W-1:0] area;
    logic [2:0]        tl_ok;
  } tcl_norm_t;

  typedef struct packed {
    tcl_wide_t [2:0]  e;
    logic [TOL_W-1:0] tol;
    logic [2:0]       tl_ok;
  } tcl_tol_t;

endpackage
`default_nettype wire

// ===== hdl/tcl_edge.sv =====
// Three-stage edge function unit: coordinate differences, products, edge sums.
// Also classifies each triangle edge under the top-left rule. Uses tcl_pkg.
`default_nettype none
module tcl_edge
  import tcl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  tcl_item_t  in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output tcl_edges_t out_data
);

  function automatic tcl_diff_t sub(input tcl_coord_t a, input tcl_coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  // Edge from a to b is top-left if it runs left on a horizontal, or rises in v.
  function automatic logic top_left(input tcl_coord_t au, input tcl_coord_t av,
                                    input tcl_coord_t bu, input tcl_coord_t bv);
    return (bv == av) ? (bu < au) : (bv > av);
  endfunction

  logic      vld1, vld2, vld3;
  logic      adv1, adv2, adv3;
  tcl_diff_t da [3][2];
  tcl_diff_t db [3][2];
  tcl_prod_t prod [3][2];
  tcl_tl_t   tl1, tl2;

  assign adv3      = !vld3 || !out_stall;
  assign adv2      = !vld2 || adv3;
  assign adv1      = !vld1 || adv2;
  assign in_stall  = !adv1;
  assign out_valid = vld3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      if (adv1) vld1 <= in_valid;
      if (adv2) vld2 <= vld1;
      if (adv3) vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      da[0][0] <= sub(in_item.u1, in_item.u2);
      db[0][0] <= sub(in_item.v2, in_item.pv);
      da[0][1] <= sub(in_item.v1, in_item.v2);
      db[0][1] <= sub(in_item.pu, in_item.u2);
      da[1][0] <= sub(in_item.u2, in_item.u0);
      db[1][0] <= sub(in_item.v0, in_item.pv);
      da[1][1] <= sub(in_item.v2, in_item.v0);
      db[1][1] <= sub(in_item.pu, in_item.u0);
      da[2][0] <= sub(in_item.u0, in_item.u1);
      db[2][0] <= sub(in_item.v1, in_item.pv);
      da[2][1] <= sub(in_item.v0, in_item.v1);
      db[2][1] <= sub(in_item.pu, in_item.u1);
      tl1.fwd[0] <= top_left(in_item.u1, in_item.v1, in_item.u2, in_item.v2);
      tl1.fwd[1] <= top_left(in_item.u2, in_item.v2, in_item.u0, in_item.v0);
      tl1.fwd[2] <= top_left(in_item.u0, in_item.v0, in_item.u1, in_item.v1);
      tl1.rev[0] <= top_left(in_item.u2, in_item.v2, in_item.u1, in_item.v1);
      tl1.rev[1] <= top_left(in_item.u0, in_item.v0, in_item.u2, in_item.v2);
      tl1.rev[2] <= top_left(in_item.u1, in_item.v1, in_item.u0, in_item.v0);
    end
    if (adv2) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 2; j++) begin
          prod[i][j] <= PROD_W'(da[i][j]) * PROD_W'(db[i][j]);
        end
      end
      tl2 <= tl1;
    end
    if (adv3) begin
      for (int i = 0; i < 3; i++) begin
        out_data.e[i] <= EDGE_W'(prod[i][0]) + EDGE_W'(prod[i][1]);
      end
      out_data.tl <= tl2;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tcl_norm.sv =====
// Two-stage orientation unit: sums the signed area, then makes it positive.
// Zero area turns every weight into one third. Uses tcl_pkg.
`default_nettype none
module tcl_norm
  import tcl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  tcl_edges_t in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output tcl_norm_t  out_data
);

  logic      vld1, vld2;
  logic      adv1, adv2;
  tcl_wide_t e1 [3];
  tcl_wide_t area1;
  tcl_tl_t   tl1;
  logic      zero, neg;

  assign adv2      = !vld2 || !out_stall;
  assign adv1      = !vld1 || adv2;
  assign in_stall  = !adv1;
  assign out_valid = vld2;

  assign zero = (area1 == '0);
  assign neg  = area1[AREA_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      if (adv1) vld1 <= in_valid;
      if (adv2) vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= AREA_W'($signed(in_data.e[i]));
      end
      area1 <= AREA_W'($signed(in_data.e[0])) + AREA_W'($signed(in_data.e[1]))
             + AREA_W'($signed(in_data.e[2]));
      tl1 <= in_data.tl;
    end
    if (adv2) begin
      for (int i = 0; i < 3; i++) begin
        if (zero) begin
          out_data.e[i] <= AREA_W'(1);
        end else if (neg) begin
          out_data.e[i] <= -e1[i];
        end else begin
          out_data.e[i] <= e1[i];
        end
      end
      if (zero) begin
        out_data.area <= AREA_W'(3);
      end else if (neg) begin
        out_data.area <= AREA_W'(-area1);
      end else begin
        out_data.area <= AREA_W'(area1);
      end
      out_data.tl_ok <= neg ? tl1.rev : tl1.fwd;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tcl_scale.sv =====
// Two-stage tolerance unit: area times epsilon as two partial products, then summed.
// Uses tcl_pkg.
`default_nettype none
module tcl_scale
  import tcl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [EPS_WIDTH-1:0] epsilon,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tcl_norm_t            in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tcl_tol_t             out_data
);

  logic                           vld1, vld2;
  logic                           adv1, adv2;
  logic [AREA_LO_W+EPS_WIDTH-1:0] pp_lo;
  logic [AREA_HI_W+EPS_WIDTH-1:0] pp_hi;
  tcl_wide_t [2:0]                e1;
  logic [2:0]                     tl_ok1;

  assign adv2      = !vld2 || !out_stall;
  assign adv1      = !vld1 || adv2;
  assign in_stall  = !adv1;
  assign out_valid = vld2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      if (adv1) vld1 <= in_valid;
      if (adv2) vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      pp_lo  <= (AREA_LO_W+EPS_WIDTH)'(in_data.area[AREA_LO_W-1:0])
              * (AREA_LO_W+EPS_WIDTH)'(epsilon);
      pp_hi  <= (AREA_HI_W+EPS_WIDTH)'(in_data.area[AREA_W-1:AREA_LO_W])
              * (AREA_HI_W+EPS_WIDTH)'(epsilon);
      e1     <= in_data.e;
      tl_ok1 <= in_data.tl_ok;
    end
    if (adv2) begin
      out_data.tol   <= TOL_W'(pp_lo) + (TOL_W'(pp_hi) << AREA_LO_W);
      out_data.e     <= e1;
      out_data.tl_ok <= tl_ok1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tcl_decide.sv =====
// Output stage: compares each scaled weight against the tolerance and applies
// the top-left rule to weights near zero. Uses tcl_pkg.
`default_nettype none
module tcl_decide
  import tcl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  tcl_tol_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output logic     covered
);

  logic                    vld;
  logic                    adv;
  logic [2:0]              below, near_zero;
  logic                    covered_next;
  logic signed [CMP_W-1:0] tol_ext;
  logic signed [CMP_W-1:0] scaled [3];
  logic signed [CMP_W-1:0] lo_sum [3];
  logic signed [CMP_W-1:0] hi_sum [3];

  assign adv       = !vld || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld;

  always_comb begin
    tol_ext = $signed(CMP_W'(in_data.tol));
    for (int i = 0; i < 3; i++) begin
      scaled[i]    = CMP_W'(in_data.e[i]) <<< COORD_FRAC_BITS;
      lo_sum[i]    = scaled[i] + tol_ext;
      hi_sum[i]    = scaled[i] - tol_ext;
      below[i]     = lo_sum[i][CMP_W-1];
      near_zero[i] = hi_sum[i][CMP_W-1] || (hi_sum[i] == '0);
    end
    covered_next = !(|below) && !(|(near_zero & ~in_data.tl_ok));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      covered <= covered_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/triangle_coverage_top_left.sv =====
// Point-in-triangle coverage test with a top-left fill rule. Each item carries three
// vertices and a sample point in signed Q8.24; the block answers one covered bit per
// item. The datapath is a fully pipelined chain of eight register stages (three for
// edge functions, two for area and orientation, two for the epsilon-scaled tolerance,
// one for the final compare), so it accepts one item every clock while in_stall is low.
// Each result is presented from the final compare register once its item has passed
// through every stage. A stall holds a stage only while every later stage is full, so
// empty stages keep filling. edge_epsilon is written through edge_epsilon_wr and must
// only change while no item is in flight. Depends on tcl_pkg.
`default_nettype none
module triangle_coverage_top_left
  import tcl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 edge_epsilon_wr,
  input  logic [EPS_WIDTH-1:0] edge_epsilon,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tcl_coord_t           first_u,
  input  tcl_coord_t           first_v,
  input  tcl_coord_t           second_u,
  input  tcl_coord_t           second_v,
  input  tcl_coord_t           third_u,
  input  tcl_coord_t           third_v,
  input  tcl_coord_t           point_u,
  input  tcl_coord_t           point_v,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 covered
);

  logic [EPS_WIDTH-1:0] epsilon;
  tcl_item_t            item;
  tcl_edges_t           edges;
  tcl_norm_t            norm;
  tcl_tol_t             tol;
  logic                 edge_valid, edge_stall;
  logic                 norm_valid, norm_stall;
  logic                 tol_valid, tol_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (edge_epsilon_wr) begin
      epsilon <= edge_epsilon;
    end
  end

  assign item.u0 = first_u;
  assign item.v0 = first_v;
  assign item.u1 = second_u;
  assign item.v1 = second_v;
  assign item.u2 = third_u;
  assign item.v2 = third_v;
  assign item.pu = point_u;
  assign item.pv = point_v;

  tcl_edge u_edge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (item),
    .out_valid (edge_valid),
    .out_stall (edge_stall),
    .out_data  (edges)
  );

  tcl_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (edge_valid),
    .in_stall  (edge_stall),
    .in_data   (edges),
    .out_valid (norm_valid),
    .out_stall (norm_stall),
    .out_data  (norm)
  );

  tcl_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .epsilon   (epsilon),
    .in_valid  (norm_valid),
    .in_stall  (norm_stall),
    .in_data   (norm),
    .out_valid (tol_valid),
    .out_stall (tol_stall),
    .out_data  (tol)
  );

  tcl_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tol_valid),
    .in_stall  (tol_stall),
    .in_data   (tol),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .covered   (covered)
  );

  // With an empty output register every stage can advance, so input is never held off.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

  // After orientation the area magnitude is never zero.
  a_area_nonzero: assert property (@(posedge clk) disable iff (rst)
    norm_valid |-> (norm.area != '0))
    else $error("normalized area is zero");

  // An item at the tolerance stage output is never lost while the compare stage holds it off.
  a_hold_in_flight: assert property (@(posedge clk) disable iff (rst)
    (tol_valid && tol_stall) |=> tol_valid)
    else $error("tolerance stage dropped an item under stall");

endmodule
`default_nettype wire

// ===== test/tb_triangle_coverage_top_left.sv =====
// Self-checking testbench for triangle_coverage_top_left: random and directed
// triangles with valid/stall handshakes on both sides, checked against a local predictor.
// Depends on tcl_pkg and the triangle_coverage_top_left RTL.
module tb_triangle_coverage_top_left;
  import tcl_pkg::*;

  typedef logic signed [127:0] acc_t;

  localparam tcl_coord_t ONE   = 32'sh0100_0000;
  localparam tcl_coord_t C_MIN = 32'sh8000_0000;
  localparam tcl_coord_t C_MAX = 32'sh7FFF_FFFF;
  localparam int PIPE_DEPTH    = 8;
  localparam int HOLD_CYCLES   = 120;
  localparam int PHASE_ITEMS   = 125;
  localparam int PHASE_COUNT   = 8;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 eps_wr = 1'b0;
  logic [EPS_WIDTH-1:0] eps_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 covered;
  tcl_item_t            offered_item = '0;

  logic [EPS_WIDTH-1:0] eps_model = EPS_RESET;
  tcl_item_t            pending_items[$];
  bit                   expected_covered[$];
  int                   send_idle_pct = 13;
  int                   recv_idle_pct = 50;
  int                   accepted_items = 0;
  int                   results_seen = 0;
  int                   covered_seen = 0;
  int                   mismatch_count = 0;
  int                   hold_left = 0;
  int                   next_hold_at = 300;
  bit                   want_covered;

  triangle_coverage_top_left u_dut (
    .clk            (clk),
    .rst            (rst),
    .edge_epsilon_wr(eps_wr),
    .edge_epsilon   (eps_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .first_u        (offered_item.u0),
    .first_v        (offered_item.v0),
    .second_u       (offered_item.u1),
    .second_v       (offered_item.v1),
    .third_u        (offered_item.u2),
    .third_v        (offered_item.v2),
    .point_u        (offered_item.pu),
    .point_v        (offered_item.pv),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .covered        (covered)
  );

  function automatic acc_t edge_value(acc_t au, acc_t av, acc_t bu, acc_t bv,
                                      acc_t cu, acc_t cv);
    return (au - bu) * (bv - cv) + (av - bv) * (cu - bu);
  endfunction

  function automatic bit is_top_left(acc_t au, acc_t av, acc_t bu, acc_t bv);
    if (bv == av) begin
      return bu < au;
    end
    return bv > av;
  endfunction

  function automatic bit predict_covered(tcl_item_t it, logic [EPS_WIDTH-1:0] eps);
    acc_t vu[3], vv[3], e[3];
    acc_t pu, pv, area, tol, shifted, eps_wide;
    bit   near_edge[3];
    bit   swap, cov, n1, n2;
    int   i1, i2;
    vu[0] = it.u0; vv[0] = it.v0;
    vu[1] = it.u1; vv[1] = it.v1;
    vu[2] = it.u2; vv[2] = it.v2;
    pu = it.pu;
    pv = it.pv;
    e[0] = edge_value(vu[1], vv[1], vu[2], vv[2], pu, pv);
    e[1] = edge_value(vu[2], vv[2], vu[0], vv[0], pu, pv);
    e[2] = edge_value(vu[0], vv[0], vu[1], vv[1], pu, pv);
    area = e[0] + e[1] + e[2];
    swap = 1'b0;
    cov = 1'b1;
    if (area == 0) begin
      for (int i = 0; i < 3; i++) e[i] = 1;
      area = 3;
    end else if (area < 0) begin
      for (int i = 0; i < 3; i++) e[i] = -e[i];
      area = -area;
      swap = 1'b1;
    end
    eps_wide = {{(128 - EPS_WIDTH){1'b0}}, eps};
    tol = area * eps_wide;
    for (int i = 0; i < 3; i++) begin
      shifted = e[i] <<< COORD_FRAC_BITS;
      if (shifted + tol < 0) cov = 1'b0;
      near_edge[i] = (shifted - tol) <= 0;
    end
    if (cov && (near_edge[0] || near_edge[1] || near_edge[2])) begin
      i1 = swap ? 2 : 1;
      i2 = swap ? 1 : 2;
      n1 = swap ? near_edge[2] : near_edge[1];
      n2 = swap ? near_edge[1] : near_edge[2];
      if (near_edge[0] && !is_top_left(vu[i1], vv[i1], vu[i2], vv[i2])) cov = 1'b0;
      if (n1 && !is_top_left(vu[i2], vv[i2], vu[0], vv[0])) cov = 1'b0;
      if (n2 && !is_top_left(vu[0], vv[0], vu[i1], vv[i1])) cov = 1'b0;
    end
    return cov;
  endfunction

  function automatic tcl_item_t tri_item(tcl_coord_t u0, tcl_coord_t v0, tcl_coord_t u1,
                                         tcl_coord_t v1, tcl_coord_t u2, tcl_coord_t v2,
                                         tcl_coord_t pu, tcl_coord_t pv);
    return {u0, v0, u1, v1, u2, v2, pu, pv};
  endfunction

  // Most items sit on a coarse grid so that shared edges, axis-aligned edges,
  // vertices and degenerate triangles come up often.
  function automatic tcl_item_t random_item();
    tcl_coord_t c[8];
    int kind, sh, a, b, g;
    kind = $urandom_range(0, 9);
    sh = $urandom_range(16, 25);
    for (int i = 0; i < 8; i++) begin
      g = $urandom_range(0, 8);
      c[i] = tcl_coord_t'(g - 4) <<< sh;
    end
    a = $urandom_range(0, 2);
    b = (a + 1 + $urandom_range(0, 1)) % 3;
    case (kind)
      0: begin
        for (int i = 0; i < 8; i++) c[i] = $urandom;
      end
      1, 2: begin
        for (int i = 0; i < 8; i++) begin
          c[i] = $urandom_range(0, 32'h07FF_FFFF);
          c[i] = c[i] - 32'sh0400_0000;
        end
      end
      3: begin
        c[6] = c[2 * a];
        c[7] = c[2 * a + 1];
      end
      4, 5: begin
        c[6] = (c[2 * a] + c[2 * b]) >>> 1;
        c[7] = (c[2 * a + 1] + c[2 * b + 1]) >>> 1;
        if (kind == 5) begin
          c[6] = c[6] + tcl_coord_t'(int'($urandom_range(0, 6)) - 3);
          c[7] = c[7] + tcl_coord_t'(int'($urandom_range(0, 6)) - 3);
        end
      end
      6: begin
        if ($urandom_range(0, 1) == 0) begin
          c[4] = c[0];
          c[5] = c[1];
        end else begin
          c[4] = 2 * c[2] - c[0];
          c[5] = 2 * c[3] - c[1];
        end
        if ($urandom_range(0, 1) == 0) begin
          c[6] = c[2];
          c[7] = c[3];
        end
      end
      7: begin
        for (int i = 0; i < 8; i++) begin
          case ($urandom_range(0, 5))
            0: c[i] = C_MIN;
            1: c[i] = C_MAX;
            2: c[i] = 0;
            3: c[i] = -1;
            4: c[i] = 1;
            default: c[i] = $urandom;
          endcase
        end
      end
      default: ;
    endcase
    return {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]};
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_covered.size() != 0);
  endtask

  task automatic write_epsilon(input logic [EPS_WIDTH-1:0] value);
    @(posedge clk);
    eps_wr <= 1'b1;
    eps_data <= value;
    eps_model <= value;
    @(posedge clk);
    eps_wr <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_covered.push_back(predict_covered(offered_item, eps_model));
        accepted_items <= accepted_items + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver occasionally holds off for a long stretch so that the
  // pipeline fills and pushes back on the sender.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (accepted_items >= next_hold_at) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 400;
    end else begin
      out_stall <= $urandom_range(0, 99) < recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_covered.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual covered=%0b", $time, covered);
        mismatch_count++;
      end else begin
        want_covered = expected_covered.pop_front();
        results_seen++;
        if (covered) covered_seen++;
        if (covered !== want_covered) begin
          $display("%0t: covered mismatch, expected %0b, actual %0b",
                   $time, want_covered, covered);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [EPS_WIDTH-1:0] phase_eps;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    pending_items.push_back(tri_item(0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(tri_item(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
    pending_items.push_back(tri_item(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
    pending_items.push_back(tri_item(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 0, 0));
    pending_items.push_back(tri_item(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, -1, 1));
    pending_items.push_back(tri_item(0, 0, 4 * ONE, 0, 0, 4 * ONE, ONE, ONE));
    pending_items.push_back(tri_item(0, 0, 0, 4 * ONE, 4 * ONE, 0, ONE, ONE));
    pending_items.push_back(tri_item(0, 0, 4 * ONE, 0, 0, 4 * ONE, 2 * ONE, 0));
    pending_items.push_back(tri_item(0, 0, 0, 4 * ONE, 4 * ONE, 0, 2 * ONE, 0));
    pending_items.push_back(tri_item(0, 0, 4 * ONE, 0, 0, 4 * ONE, 0, 2 * ONE));
    pending_items.push_back(tri_item(0, 0, 0, 4 * ONE, 4 * ONE, 0, 0, 2 * ONE));
    pending_items.push_back(tri_item(0, 0, 4 * ONE, 0, 0, 4 * ONE, 2 * ONE, 2 * ONE));
    pending_items.push_back(tri_item(0, 0, 4 * ONE, 0, 0, 4 * ONE, 0, 0));
    pending_items.push_back(tri_item(0, 0, 4 * ONE, 0, 0, 4 * ONE, 5 * ONE, 5 * ONE));
    pending_items.push_back(tri_item(0, 0, 4 * ONE, 0, 0, 4 * ONE, 2 * ONE, -1));
    pending_items.push_back(tri_item(0, 0, 4 * ONE, 0, 0, 4 * ONE, 2 * ONE, 1));
    pending_items.push_back(tri_item(ONE, ONE, ONE, ONE, ONE, ONE, 7 * ONE, 7 * ONE));
    pending_items.push_back(tri_item(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 5 * ONE, 0));
    pending_items.push_back(tri_item(0, 4 * ONE, 4 * ONE, 4 * ONE, 2 * ONE, 0, 2 * ONE, 4 * ONE));
    pending_items.push_back(tri_item(4 * ONE, 4 * ONE, 0, 4 * ONE, 2 * ONE, 0, 2 * ONE, 4 * ONE));
    pending_items.push_back(tri_item(0, 4 * ONE, 4 * ONE, 4 * ONE, 2 * ONE, 0, 3 * ONE, 2 * ONE));
    pending_items.push_back(tri_item(0, 4 * ONE, 4 * ONE, 4 * ONE, 2 * ONE, 0, ONE, 2 * ONE));
    wait_idle();

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: phase_eps = EPS_RESET;
        1: phase_eps = '0;
        2: phase_eps = 25'd16777216;
        3: phase_eps = 25'h1FF_FFFF;
        4: phase_eps = 25'd5592405;
        5: phase_eps = 25'd5592406;
        6: phase_eps = $urandom_range(0, 25'h1FF_FFFF);
        default: phase_eps = $urandom_range(0, 1023);
      endcase
      write_epsilon(phase_eps);
      @(negedge clk);
      send_idle_pct = (phase < 3) ? 13 : (phase < 6) ? 50 : 0;
      recv_idle_pct = (phase < 3) ? 50 : (phase < 6) ? 13 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) pending_items.push_back(random_item());
      wait_idle();
    end

    repeat (2 * PIPE_DEPTH) @(posedge clk);
    $display("Checked %0d coverage results (%0d covered) over %0d epsilon settings,",
             results_seen, covered_seen, PHASE_COUNT + 1);
    $display("with input gaps, output stalls and long output hold-offs.");
    if (mismatch_count == 0 && expected_covered.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tcl_pkg.sv
hdl/tcl_edge.sv
hdl/tcl_norm.sv
hdl/tcl_scale.sv
hdl/tcl_decide.sv
hdl/triangle_coverage_top_left.sv
test/tb_triangle_coverage_top_left.sv
